// ----- sv/i2c_register_access_sequencer_defines.svh -----
// assertion macros for the i2c register access sequencer checker
// no dependencies; included by the checker file
`ifndef I2C_REGISTER_ACCESS_SEQUENCER_DEFINES_SVH
`define I2C_REGISTER_ACCESS_SEQUENCER_DEFINES_SVH

// property holds on every edge outside reset
`define I2CRAS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent on one edge implies consequent on the next
`define I2CRAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/i2cras_pkg.sv -----
// codes shared by the i2c register access sequencer and its checker
// no dependencies
package i2cras_pkg;

   localparam logic [1:0] ACT_REQUEST  = 2'd0;
   localparam logic [1:0] ACT_COMPLETE = 2'd1;
   localparam logic [1:0] ACT_TICK     = 2'd2;

   localparam logic [2:0] OP_RD1  = 3'd0;
   localparam logic [2:0] OP_WR1  = 3'd1;
   localparam logic [2:0] OP_RDB  = 3'd2;
   localparam logic [2:0] OP_WRB  = 3'd3;
   localparam logic [2:0] OP_FILL = 3'd4;

   localparam logic [2:0] CMD_NONE    = 3'd0;
   localparam logic [2:0] CMD_START   = 3'd1;
   localparam logic [2:0] CMD_SEND    = 3'd2;
   localparam logic [2:0] CMD_RXACK   = 3'd3;
   localparam logic [2:0] CMD_RXNACK  = 3'd4;
   localparam logic [2:0] CMD_STOP    = 3'd5;
   localparam logic [2:0] CMD_DISABLE = 3'd6;

   localparam logic [3:0] ST_START     = 4'd0;
   localparam logic [3:0] ST_REPSTART  = 4'd1;
   localparam logic [3:0] ST_AW_ACK    = 4'd2;
   localparam logic [3:0] ST_DATA_ACK  = 4'd3;
   localparam logic [3:0] ST_AR_ACK    = 4'd4;
   localparam logic [3:0] ST_RX_NACK   = 4'd6;
   localparam logic [3:0] ST_IDLE      = 4'd7;

   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_START    = 4'd1;
   localparam logic [3:0] PH_ADDRW    = 4'd2;
   localparam logic [3:0] PH_REG      = 4'd3;
   localparam logic [3:0] PH_REPSTART = 4'd4;
   localparam logic [3:0] PH_ADDRR    = 4'd5;
   localparam logic [3:0] PH_RX       = 4'd6;
   localparam logic [3:0] PH_WDATA    = 4'd7;
   localparam logic [3:0] PH_STOP     = 4'd8;

   localparam logic [7:0] TIMEOUT_RESET = 8'hFF;

   typedef logic [2:0]  command_type;
   typedef logic [15:0] count_type;

endpackage

// ----- sv/i2c_register_access_sequencer.sv -----
// channel  | direction | beat contents
// req_     | in        | action, operation, addresses, count, data, bus status, rx data
// rsp_     | out       | command, tx byte, rx byte and flags, done, success, error count
// csr_     | in        | timeout_ticks write, no handshake
// one beat per cycle: each event is decided in the cycle it is accepted and
// the result is held in one output register; req_ready is low only while that
// register is full and not taken. events that give no result are accepted at that rate too.
// synchronous active-high reset returns to idle with timeout 255.
// depends on i2cras_pkg
module i2c_register_access_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_action,
   input  logic [2:0]              req_operation,
   input  logic [6:0]              req_device_address,
   input  logic [7:0]              req_register_address,
   input  logic [7:0]              req_byte_count,
   input  logic [7:0]              req_write_data,
   input  logic [3:0]              req_bus_status,
   input  logic [7:0]              req_rx_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output i2cras_pkg::command_type rsp_command,
   output logic [7:0]              rsp_tx_byte,
   output logic [7:0]              rsp_rx_byte,
   output logic                    rsp_rx_valid,
   output logic                    rsp_rx_last,
   output logic                    rsp_done_res,
   output logic                    rsp_success,
   output i2cras_pkg::count_type   rsp_error_count,
   input  logic                    csr_write_enable,
   input  logic [7:0]              csr_write_data
);
   import i2cras_pkg::*;

   logic [7:0]  timeout_ff;
   logic [3:0]  phase_ff, phase_in;
   logic [2:0]  operation_ff, operation_in;
   logic [6:0]  address_ff, address_in;
   logic [7:0]  register_ff, register_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic [7:0]  wait_ticks_ff, wait_ticks_in;
   count_type   errors_ff, errors_in;

   logic        rsp_valid_ff;
   command_type command_ff, command_in;
   logic [7:0]  tx_byte_ff, tx_byte_in;
   logic [7:0]  rx_byte_ff, rx_byte_in;
   logic        rx_valid_ff, rx_valid_in;
   logic        rx_last_ff, rx_last_in;
   logic        done_ff, done_in;
   logic        success_ff, success_in;
   count_type   error_count_ff;

   logic        req_accept;
   logic        fire;
   logic [7:0]  bytes_dec;
   logic [8:0]  wait_next;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign bytes_dec  = bytes_left_ff - 8'd1;
   assign wait_next  = {1'b0, wait_ticks_ff} + 9'd1;

   always_comb begin
      phase_in      = phase_ff;
      operation_in  = operation_ff;
      address_in    = address_ff;
      register_in   = register_ff;
      bytes_left_in = bytes_left_ff;
      held_byte_in  = held_byte_ff;
      wait_ticks_in = wait_ticks_ff;
      errors_in     = errors_ff;
      fire          = 1'b0;
      command_in    = CMD_NONE;
      tx_byte_in    = 8'd0;
      rx_byte_in    = 8'd0;
      rx_valid_in   = 1'b0;
      rx_last_in    = 1'b0;
      done_in       = 1'b0;
      success_in    = 1'b0;

      if (req_accept) begin
         unique case (req_action)
            ACT_REQUEST: begin
               if (phase_ff == PH_IDLE && req_operation <= OP_FILL) begin
                  fire          = 1'b1;
                  operation_in  = req_operation;
                  address_in    = req_device_address;
                  register_in   = req_register_address;
                  bytes_left_in = (req_operation == OP_RD1) ? 8'd1 : req_byte_count;
                  held_byte_in  = req_write_data;
                  command_in    = CMD_START;
                  phase_in      = PH_START;
                  wait_ticks_in = 8'd0;
               end
            end
            ACT_COMPLETE: begin
               if (phase_ff != PH_IDLE) begin
                  fire          = 1'b1;
                  wait_ticks_in = 8'd0;
                  unique case (phase_ff)
                     PH_START: begin
                        if (req_bus_status inside {ST_START, ST_REPSTART}) begin
                           command_in = CMD_SEND;
                           tx_byte_in = {address_ff, 1'b0};
                           phase_in   = PH_ADDRW;
                        end else begin
                           done_in  = 1'b1;
                           phase_in = PH_IDLE;
                        end
                     end
                     PH_ADDRW: begin
                        if (req_bus_status == ST_AW_ACK) begin
                           command_in = CMD_SEND;
                           tx_byte_in = register_ff;
                           phase_in   = PH_REG;
                        end else begin
                           done_in  = 1'b1;
                           phase_in = PH_IDLE;
                        end
                     end
                     PH_REG: begin
                        if (req_bus_status != ST_DATA_ACK) begin
                           done_in  = 1'b1;
                           phase_in = PH_IDLE;
                        end else if (operation_ff == OP_RD1 || operation_ff == OP_RDB) begin
                           command_in = CMD_START;
                           phase_in   = PH_REPSTART;
                        end else if (operation_ff == OP_WR1) begin
                           command_in = CMD_SEND;
                           tx_byte_in = held_byte_ff;
                           phase_in   = PH_WDATA;
                        end else if (bytes_left_ff == 8'd0) begin
                           command_in = CMD_STOP;
                           done_in    = 1'b1;
                           success_in = 1'b1;
                           phase_in   = PH_IDLE;
                        end else begin
                           command_in = CMD_SEND;
                           tx_byte_in = (operation_ff == OP_WRB) ? req_write_data
                                                                 : held_byte_ff;
                           phase_in   = PH_WDATA;
                        end
                     end
                     PH_REPSTART: begin
                        if (req_bus_status == ST_REPSTART) begin
                           command_in = CMD_SEND;
                           tx_byte_in = {address_ff, 1'b1};
                           phase_in   = PH_ADDRR;
                        end else begin
                           done_in  = 1'b1;
                           phase_in = PH_IDLE;
                        end
                     end
                     PH_ADDRR: begin
                        if (req_bus_status != ST_AR_ACK) begin
                           done_in  = 1'b1;
                           phase_in = PH_IDLE;
                        end else if (bytes_left_ff == 8'd0) begin
                           command_in = CMD_STOP;
                           phase_in   = PH_STOP;
                        end else begin
                           command_in = (bytes_left_ff > 8'd1) ? CMD_RXACK : CMD_RXNACK;
                           phase_in   = PH_RX;
                        end
                     end
                     PH_RX: begin
                        if (operation_ff == OP_RD1 && req_bus_status != ST_RX_NACK) begin
                           done_in  = 1'b1;
                           phase_in = PH_IDLE;
                        end else begin
                           rx_byte_in    = req_rx_data;
                           rx_valid_in   = 1'b1;
                           bytes_left_in = bytes_dec;
                           if (bytes_dec == 8'd0) begin
                              rx_last_in = 1'b1;
                              command_in = CMD_STOP;
                              phase_in   = PH_STOP;
                           end else begin
                              command_in = (bytes_dec > 8'd1) ? CMD_RXACK : CMD_RXNACK;
                              phase_in   = PH_RX;
                           end
                        end
                     end
                     PH_WDATA: begin
                        if (operation_ff == OP_WR1) begin
                           if (req_bus_status == ST_DATA_ACK) begin
                              command_in = CMD_STOP;
                              phase_in   = PH_STOP;
                           end else begin
                              done_in  = 1'b1;
                              phase_in = PH_IDLE;
                           end
                        end else if (req_bus_status != ST_DATA_ACK) begin
                           errors_in  = errors_ff + 16'd1;
                           command_in = CMD_STOP;
                           done_in    = 1'b1;
                           phase_in   = PH_IDLE;
                        end else begin
                           bytes_left_in = bytes_dec;
                           if (bytes_dec == 8'd0) begin
                              command_in = CMD_STOP;
                              done_in    = 1'b1;
                              success_in = 1'b1;
                              phase_in   = PH_IDLE;
                           end else begin
                              command_in = CMD_SEND;
                              tx_byte_in = (operation_ff == OP_WRB) ? req_write_data
                                                                    : held_byte_ff;
                              phase_in   = PH_WDATA;
                           end
                        end
                     end
                     PH_STOP: begin
                        if (req_bus_status != ST_IDLE) begin
                           errors_in = errors_ff + 16'd1;
                        end
                        done_in    = 1'b1;
                        success_in = (req_bus_status == ST_IDLE);
                        phase_in   = PH_IDLE;
                     end
                     default: begin
                        done_in  = 1'b1;
                        phase_in = PH_IDLE;
                     end
                  endcase
               end
            end
            ACT_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  if (wait_next >= {1'b0, timeout_ff}) begin
                     fire          = 1'b1;
                     errors_in     = errors_ff + 16'd1;
                     command_in    = CMD_DISABLE;
                     done_in       = 1'b1;
                     phase_in      = PH_IDLE;
                     wait_ticks_in = 8'd0;
                  end else begin
                     wait_ticks_in = wait_next[7:0];
                  end
               end
            end
            default: begin
               fire = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RESET;
         phase_ff      <= PH_IDLE;
         operation_ff  <= OP_RD1;
         address_ff    <= 7'd0;
         register_ff   <= 8'd0;
         bytes_left_ff <= 8'd0;
         held_byte_ff  <= 8'd0;
         wait_ticks_ff <= 8'd0;
         errors_ff     <= 16'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            timeout_ff <= csr_write_data;
         end
         phase_ff      <= phase_in;
         operation_ff  <= operation_in;
         address_ff    <= address_in;
         register_ff   <= register_in;
         bytes_left_ff <= bytes_left_in;
         held_byte_ff  <= held_byte_in;
         wait_ticks_ff <= wait_ticks_in;
         errors_ff     <= errors_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, loaded only with a new beat
   always_ff @(posedge clock) begin
      if (fire) begin
         command_ff     <= command_in;
         tx_byte_ff     <= tx_byte_in;
         rx_byte_ff     <= rx_byte_in;
         rx_valid_ff    <= rx_valid_in;
         rx_last_ff     <= rx_last_in;
         done_ff        <= done_in;
         success_ff     <= success_in;
         error_count_ff <= errors_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_command     = command_ff;
   assign rsp_tx_byte     = tx_byte_ff;
   assign rsp_rx_byte     = rx_byte_ff;
   assign rsp_rx_valid    = rx_valid_ff;
   assign rsp_rx_last     = rx_last_ff;
   assign rsp_done_res    = done_ff;
   assign rsp_success     = success_ff;
   assign rsp_error_count = error_count_ff;

endmodule

// ----- sv/i2cras_checker.sv -----
// port-level checks for the i2c register access sequencer, with its bind
// depends on i2cras_pkg and i2c_register_access_sequencer_defines.svh
`include "i2c_register_access_sequencer_defines.svh"

module i2cras_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input i2cras_pkg::command_type rsp_command,
   input logic [7:0]              rsp_tx_byte,
   input logic [7:0]              rsp_rx_byte,
   input logic                    rsp_rx_valid,
   input logic                    rsp_rx_last,
   input logic                    rsp_done_res,
   input logic                    rsp_success,
   input i2cras_pkg::count_type   rsp_error_count
);
   import i2cras_pkg::*;

   logic        stalled;
   logic        success_ok;
   logic        last_ok;
   logic        disable_ok;
   logic        ready_ok;
   logic [38:0] payload;

   assign stalled    = rsp_valid && !rsp_ready;
   assign success_ok = !(rsp_valid && rsp_success) || rsp_done_res;
   assign last_ok    = !(rsp_valid && rsp_rx_last) || rsp_rx_valid;
   assign disable_ok = !(rsp_valid && rsp_command == CMD_DISABLE)
                       || (rsp_done_res && !rsp_success);
   assign ready_ok   = (req_ready == (!rsp_valid || rsp_ready));
   assign payload    = {rsp_command, rsp_tx_byte, rsp_rx_byte, rsp_rx_valid, rsp_rx_last,
                        rsp_done_res, rsp_success, rsp_error_count};

   `I2CRAS_ASSERT(a_success_needs_done, clock, reset, success_ok, "success without done")
   `I2CRAS_ASSERT(a_last_needs_rx, clock, reset, last_ok, "rx_last without rx_valid")
   `I2CRAS_ASSERT(a_disable_fails, clock, reset, disable_ok, "disable not a failure")
   `I2CRAS_ASSERT_NEXT(a_stall_holds, clock, reset, stalled, rsp_valid && $stable(payload), "stalled beat changed")
   `I2CRAS_ASSERT(a_ready_follows_rsp, clock, reset, ready_ok, "input ready out of step")

endmodule

bind i2c_register_access_sequencer i2cras_checker u_i2cras_checker (.*);
